/* design/slm_pkg.sv */
package slm_pkg;

  // Input sample and accumulator widths.
  localparam int SAMPLE_W = 32;
  localparam int MAG_W    = 31;
  localparam int SUM_W    = 36;

  // Block length and the width of the sample counter that can hold it.
  localparam int BLOCK_SAMPLES = 16;
  localparam int CNT_W         = $clog2(BLOCK_SAMPLES + 1);

  // Log and level formats.
  localparam int FRAC_BITS = 16;
  localparam int EXP_W     = 5;
  localparam int LOG_W     = EXP_W + FRAC_BITS;
  localparam int OFF_W     = 12;
  localparam int LEVEL_W   = 11;
  localparam int OUT_W     = 16;

  // 16 * 20 * log10(2) in Q7.16.
  localparam int K_W = 23;
  localparam logic [K_W-1:0] DB_PER_LOG2 = K_W'(6313057);

  // Upper clamp of the level, 120 dB in 1/16 dB steps.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(1920);

endpackage

/* design/slm_div.sv */
// Restoring divider: one quotient bit per cycle, the dividend shifted through
// the quotient register. The divisor is a small sample count.
module slm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [slm_pkg::SUM_W-1:0]     dividend_i,
  input  logic [slm_pkg::CNT_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [slm_pkg::SUM_W-1:0]     quot_o
);

  localparam int STEP_W = $clog2(slm_pkg::SUM_W);

  logic                          busy_q;
  logic                          done_q;
  logic [STEP_W-1:0]             step_q;
  logic [slm_pkg::SUM_W-1:0]     quot_q;
  logic [slm_pkg::CNT_W-1:0]     rem_q;
  logic [slm_pkg::CNT_W-1:0]     div_q;

  logic [slm_pkg::CNT_W:0]       trial;
  logic                          fits;
  logic [slm_pkg::CNT_W:0]       diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_q, quot_q[slm_pkg::SUM_W-1]};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(slm_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[slm_pkg::SUM_W-2:0], fits};
      rem_q  <= fits ? diff[slm_pkg::CNT_W-1:0] : trial[slm_pkg::CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* design/slm_log.sv */
// Level from the block mean: leading-one search by shifting, then sixteen
// squarings of the mantissa for the log2 fraction, then scaling to 1/16 dB.
// One multiplier serves the squarings and the final scaling.
module slm_log (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [slm_pkg::MAG_W-1:0]           mean_i,
  input  logic signed [slm_pkg::OFF_W-1:0]    offset_i,
  output logic                                done_o,
  output logic [slm_pkg::LEVEL_W-1:0]         level_o
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_NORM,
    L_SQR,
    L_SCALE,
    L_FIN
  } log_state_e;

  localparam int RND_W  = $clog2(slm_pkg::FRAC_BITS);
  localparam int PROD_W = slm_pkg::LOG_W + slm_pkg::K_W;
  localparam int LVL_W  = 14;

  log_state_e                        state_q;
  logic                              done_q;
  logic                              zero_q;
  logic [slm_pkg::MAG_W-1:0]         m_q;
  logic [slm_pkg::EXP_W-1:0]         p_q;
  logic [slm_pkg::FRAC_BITS-1:0]     frac_q;
  logic [RND_W-1:0]                  rnd_q;
  logic [PROD_W-1:0]                 prod_q;
  logic [slm_pkg::LEVEL_W-1:0]       level_q;

  logic [31:0]                       op_a;
  logic [31:0]                       op_b;
  logic [63:0]                       prod;
  logic [PROD_W:0]                   rounded;
  logic signed [LVL_W-1:0]           lvl;

  // Shared multiplier: squares the mantissa, or scales log2 by dB per octave.
  always_comb begin
    if (state_q == L_SCALE) begin
      op_a = 32'({p_q, frac_q});
      op_b = 32'(slm_pkg::DB_PER_LOG2);
    end else begin
      op_a = 32'(m_q);
      op_b = 32'(m_q);
    end
    prod = op_a * op_b;
  end

  // Round to nearest, add the calibration offset.
  always_comb begin
    rounded = {1'b0, prod_q} + (PROD_W + 1)'(64'h8000_0000);
    lvl     = $signed({1'b0, rounded[PROD_W:32]})
            + $signed({{(LVL_W - slm_pkg::OFF_W){offset_i[slm_pkg::OFF_W-1]}}, offset_i});
  end

  // Sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
      rnd_q   <= '0;
      level_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            zero_q  <= (mean_i == '0);
            rnd_q   <= '0;
            state_q <= (mean_i == '0) ? L_FIN : L_NORM;
          end
        end
        L_NORM: begin
          if (m_q[slm_pkg::MAG_W-1]) begin
            state_q <= L_SQR;
          end
        end
        L_SQR: begin
          rnd_q <= rnd_q + RND_W'(1);
          if (rnd_q == RND_W'(slm_pkg::FRAC_BITS - 1)) begin
            state_q <= L_SCALE;
          end
        end
        L_SCALE: begin
          state_q <= L_FIN;
        end
        L_FIN: begin
          if (zero_q || lvl < 0) begin
            level_q <= '0;
          end else if (lvl > $signed({3'b000, slm_pkg::LEVEL_MAX})) begin
            level_q <= slm_pkg::LEVEL_MAX;
          end else begin
            level_q <= lvl[slm_pkg::LEVEL_W-1:0];
          end
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  // Mantissa, exponent and fraction registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        m_q    <= mean_i;
        p_q    <= slm_pkg::EXP_W'(slm_pkg::MAG_W - 1);
        frac_q <= '0;
      end
      L_NORM: begin
        if (!m_q[slm_pkg::MAG_W-1]) begin
          m_q <= {m_q[slm_pkg::MAG_W-2:0], 1'b0};
          p_q <= p_q - slm_pkg::EXP_W'(1);
        end
      end
      L_SQR: begin
        // A square at or above two yields a fraction bit and a halving.
        frac_q <= {frac_q[slm_pkg::FRAC_BITS-2:0], prod[61]};
        m_q    <= prod[61] ? prod[61:31] : prod[60:30];
      end
      L_SCALE: begin
        prod_q <= prod[PROD_W-1:0];
      end
      default: begin
      end
    endcase
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

/* design/sound_level_meter_db.sv */
// Samples that do not end a block are accepted whenever valid, so the samples
// of a block stream at one per cycle. A block-ending sample has its level
// offered once the divider steps, the normalizing shifts, the 16 squarings,
// the scaling and the clamp are through; a zero mean skips shifts and squarings.
// No sample is taken until then, or longer while an earlier level still waits.
// Reset clears the accumulator, the sample count and the offset to zero.
module sound_level_meter_db (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fields: sample [31:0].
  input  logic [31:0]                         s_axis_tdata,
  // Field: block_end.
  input  logic                                s_axis_tlast,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields: level [10:0], zero padding [15:11].
  output logic [15:0]                         m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [slm_pkg::OFF_W-1:0]           cfg_data_i
);

  typedef enum logic [1:0] {
    S_ACC,
    S_DIV,
    S_LOG,
    S_PUT
  } top_state_e;

  top_state_e                        state_q;
  logic [slm_pkg::SUM_W-1:0]         sum_q;
  logic [slm_pkg::CNT_W-1:0]         cnt_q;
  logic signed [slm_pkg::OFF_W-1:0]  offset_q;
  logic                              out_valid_q;
  logic [slm_pkg::LEVEL_W-1:0]       out_level_q;

  logic                              in_xfer;
  logic [slm_pkg::SAMPLE_W-1:0]      neg;
  logic [slm_pkg::MAG_W-1:0]         mag;
  logic [slm_pkg::SUM_W:0]           sum_ext;
  logic [slm_pkg::SUM_W-1:0]         sum_next;
  logic [slm_pkg::CNT_W-1:0]         cnt_next;
  logic                              block_done;
  logic                              div_start;
  logic                              div_done;
  logic [slm_pkg::SUM_W-1:0]         quot;
  logic [slm_pkg::MAG_W-1:0]         mean;
  logic                              log_done;
  logic [slm_pkg::LEVEL_W-1:0]       log_level;
  logic                              put_ok;

  assign s_axis_tready = (state_q == S_ACC);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Sample magnitude, with the most negative value saturated.
  always_comb begin
    neg = ~s_axis_tdata + slm_pkg::SAMPLE_W'(1);
    if (!s_axis_tdata[slm_pkg::SAMPLE_W-1]) begin
      mag = s_axis_tdata[slm_pkg::MAG_W-1:0];
    end else if (neg[slm_pkg::SAMPLE_W-1]) begin
      mag = '1;
    end else begin
      mag = neg[slm_pkg::MAG_W-1:0];
    end
  end

  // Saturating accumulation and end-of-block detection.
  always_comb begin
    sum_ext    = {1'b0, sum_q} + (slm_pkg::SUM_W + 1)'(mag);
    sum_next   = sum_ext[slm_pkg::SUM_W] ? '1 : sum_ext[slm_pkg::SUM_W-1:0];
    cnt_next   = cnt_q + slm_pkg::CNT_W'(1);
    block_done = s_axis_tlast || (cnt_next == slm_pkg::CNT_W'(slm_pkg::BLOCK_SAMPLES));
  end

  assign div_start = in_xfer && block_done;

  slm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_next),
    .divisor_i  (cnt_next),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // The mean cannot exceed the largest magnitude; clamp anyway.
  assign mean = (|quot[slm_pkg::SUM_W-1:slm_pkg::MAG_W]) ? '1 : quot[slm_pkg::MAG_W-1:0];

  slm_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_done),
    .mean_i   (mean),
    .offset_i (offset_q),
    .done_o   (log_done),
    .level_o  (log_level)
  );

  assign put_ok = !out_valid_q || m_axis_tready;

  // Sequencer, accumulator, offset register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      sum_q       <= '0;
      cnt_q       <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
      out_level_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_data_i;
      end
      // A level leaves on its transfer unless a new one is loaded at once.
      if (out_valid_q && m_axis_tready && (state_q != S_PUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_ACC: begin
          if (in_xfer) begin
            if (block_done) begin
              sum_q   <= '0;
              cnt_q   <= '0;
              state_q <= S_DIV;
            end else begin
              sum_q <= sum_next;
              cnt_q <= cnt_next;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_LOG;
          end
        end
        S_LOG: begin
          if (log_done) begin
            state_q <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_ok) begin
            out_valid_q <= 1'b1;
            out_level_q <= log_level;
            state_q     <= S_ACC;
          end
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = slm_pkg::OUT_W'(out_level_q);

endmodule
